FILE: src/sstg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sstg_pkg: shared types, constants and tables of the swept siren generator
// Holds the register map, the configuration and queue entry structs, the
// phase scaling helpers and the quarter-wave sine table.
// ---------------------------------------------------------------------------
package sstg_pkg;

   localparam int SINE_TABLE_BITS = 10;
   localparam int PHASE_BITS      = 32;
   localparam int QTAB_LEN        = (1 << SINE_TABLE_BITS) + 1;
   localparam int QIDX_BITS       = SINE_TABLE_BITS + 1;
   localparam int COUNT_BITS      = 24;
   localparam int ENV_BITS        = 17;
   localparam int CSR_ADDR_BITS   = 5;
   localparam int CSR_DATA_BITS   = 32;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);

   localparam logic [ENV_BITS-1:0] ENV_ONE = ENV_BITS'(65536);

   typedef enum logic [2:0] {
      CSR_START_INC = 3'd0,
      CSR_SPAN_INC  = 3'd1,
      CSR_LFO_INC   = 3'd2,
      CSR_TOTAL     = 3'd3,
      CSR_FADE_LEN  = 3'd4,
      CSR_FADE_STEP = 3'd5,
      CSR_GAIN      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [30:0]           start_increment;
      logic [30:0]           span_increment;
      logic [31:0]           lfo_increment;
      logic [COUNT_BITS-1:0] total_samples;
      logic [15:0]           fade_len;
      logic [ENV_BITS-1:0]   fade_step;
      logic [14:0]           gain;
   } cfg_type;

   localparam logic [30:0]           RST_START_INC = 31'd68174085;
   localparam logic [30:0]           RST_SPAN_INC  = 31'd77913240;
   localparam logic [31:0]           RST_LFO_INC   = 32'd19478;
   localparam logic [COUNT_BITS-1:0] RST_TOTAL     = COUNT_BITS'(441000);
   localparam logic [15:0]           RST_FADE_LEN  = 16'd441;
   localparam logic [ENV_BITS-1:0]   RST_FADE_STEP = ENV_BITS'(149);
   localparam logic [14:0]           RST_GAIN      = 15'd27852;

   // one classified transaction handed from front to back
   typedef struct packed {
      logic                  restart;
      logic                  done;
      logic                  last;
      logic                  env_flat;
      logic [COUNT_BITS-1:0] env_op;
      logic [31:0]           p32;
   } job_type;

   // Q32 increment to phase accumulator width
   function automatic logic [PHASE_BITS-1:0] scale_inc(input logic [31:0] inc);
      logic [PHASE_BITS+31:0] wide;
      wide = {inc, {PHASE_BITS{1'b0}}} >> 32;
      return wide[PHASE_BITS-1:0];
   endfunction

   // top 32 bits of a phase, zero filled below when the phase is narrower
   function automatic logic [31:0] top32(input logic [PHASE_BITS-1:0] ph);
      logic [PHASE_BITS+31:0] wide;
      wide = {ph, 32'd0} >> PHASE_BITS;
      return wide[31:0];
   endfunction

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   function automatic logic [63:0] term_clip(input logic [63:0] d);
      return (d > Q30_ONE) ? 64'd0 : (Q30_ONE - d);
   endfunction

   // Taylor series of sin in Q30, rounded to Q15 magnitude
   function automatic logic [15:0] quarter_sine(input int unsigned i);
      logic [63:0] theta;
      logic [63:0] t2;
      logic [63:0] term;
      logic [63:0] s;
      logic [63:0] r;
      theta = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
      t2    = (theta * theta) >> 30;
      term  = Q30_ONE;
      term  = term_clip(((t2 * term) >> 30) / 64'd110);
      term  = term_clip(((t2 * term) >> 30) / 64'd72);
      term  = term_clip(((t2 * term) >> 30) / 64'd42);
      term  = term_clip(((t2 * term) >> 30) / 64'd20);
      term  = term_clip(((t2 * term) >> 30) / 64'd6);
      s     = (theta * term) >> 30;
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      r = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
      return r[15:0];
   endfunction

   typedef logic [15:0] qtab_type [QTAB_LEN];

   function automatic qtab_type build_qtab();
      qtab_type t;
      for (int i = 0; i < QTAB_LEN; i++) begin
         t[i] = quarter_sine(i);
      end
      return t;
   endfunction

   localparam qtab_type QTAB = build_qtab();

endpackage

FILE: src/sstg_csr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sstg_csr: configuration register file
// APB-style write and read of the seven tone registers.
// ---------------------------------------------------------------------------
module sstg_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [sstg_pkg::CSR_ADDR_BITS-1:0]      paddr,
   input  logic [sstg_pkg::CSR_DATA_BITS-1:0]      pwdata,
   output logic [sstg_pkg::CSR_DATA_BITS-1:0]      prdata,
   output sstg_pkg::cfg_type                       cfg
);

   sstg_pkg::cfg_type       cfg_ff;
   sstg_pkg::csr_index_type index;
   logic                    wr_en;

   assign index = sstg_pkg::csr_index_type'(paddr[sstg_pkg::CSR_ADDR_BITS-1:2]);
   assign wr_en = psel & penable & pwrite;
   assign cfg   = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_increment <= sstg_pkg::RST_START_INC;
         cfg_ff.span_increment  <= sstg_pkg::RST_SPAN_INC;
         cfg_ff.lfo_increment   <= sstg_pkg::RST_LFO_INC;
         cfg_ff.total_samples   <= sstg_pkg::RST_TOTAL;
         cfg_ff.fade_len        <= sstg_pkg::RST_FADE_LEN;
         cfg_ff.fade_step       <= sstg_pkg::RST_FADE_STEP;
         cfg_ff.gain            <= sstg_pkg::RST_GAIN;
      end else if (wr_en) begin
         case (index)
            sstg_pkg::CSR_START_INC: cfg_ff.start_increment <= pwdata[30:0];
            sstg_pkg::CSR_SPAN_INC:  cfg_ff.span_increment  <= pwdata[30:0];
            sstg_pkg::CSR_LFO_INC:   cfg_ff.lfo_increment   <= pwdata[31:0];
            sstg_pkg::CSR_TOTAL:     cfg_ff.total_samples   <=
                                        pwdata[sstg_pkg::COUNT_BITS-1:0];
            sstg_pkg::CSR_FADE_LEN:  cfg_ff.fade_len        <= pwdata[15:0];
            sstg_pkg::CSR_FADE_STEP: cfg_ff.fade_step       <=
                                        pwdata[sstg_pkg::ENV_BITS-1:0];
            sstg_pkg::CSR_GAIN:      cfg_ff.gain            <= pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         sstg_pkg::CSR_START_INC: prdata = 32'(cfg_ff.start_increment);
         sstg_pkg::CSR_SPAN_INC:  prdata = 32'(cfg_ff.span_increment);
         sstg_pkg::CSR_LFO_INC:   prdata = cfg_ff.lfo_increment;
         sstg_pkg::CSR_TOTAL:     prdata = 32'(cfg_ff.total_samples);
         sstg_pkg::CSR_FADE_LEN:  prdata = 32'(cfg_ff.fade_len);
         sstg_pkg::CSR_FADE_STEP: prdata = 32'(cfg_ff.fade_step);
         sstg_pkg::CSR_GAIN:      prdata = 32'(cfg_ff.gain);
         default:                 prdata = '0;
      endcase
   end

endmodule

FILE: src/sstg_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sstg_front: transaction intake and classification
// Owns the sweep phase and sample counter; tags each transaction as done,
// last or in a fade ramp and hands it to the queue.
// ---------------------------------------------------------------------------
module sstg_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_restart,
   output logic                req_stall,
   input  sstg_pkg::cfg_type   cfg,
   input  logic                q_full,
   output logic                push,
   output sstg_pkg::job_type   push_data
);

   logic [sstg_pkg::PHASE_BITS-1:0] sweep_ff, sweep_in, sweep_base;
   logic [sstg_pkg::COUNT_BITS-1:0] count_ff, count_in, n;
   logic [sstg_pkg::COUNT_BITS:0]   n_plus_fade, n_plus_one;
   logic                            done, fade_in, fade_out;

   assign req_stall = q_full;
   assign push      = req_valid & ~q_full;

   always_comb begin
      n           = req_restart ? '0 : count_ff;
      sweep_base  = req_restart ? '0 : sweep_ff;
      done        = n >= cfg.total_samples;
      fade_in     = n < sstg_pkg::COUNT_BITS'(cfg.fade_len);
      n_plus_fade = (sstg_pkg::COUNT_BITS+1)'(n) + (sstg_pkg::COUNT_BITS+1)'(cfg.fade_len);
      n_plus_one  = (sstg_pkg::COUNT_BITS+1)'(n) + (sstg_pkg::COUNT_BITS+1)'(1);
      fade_out    = n_plus_fade > (sstg_pkg::COUNT_BITS+1)'(cfg.total_samples);

      push_data.restart  = req_restart;
      push_data.done     = done;
      push_data.last     = n_plus_one == (sstg_pkg::COUNT_BITS+1)'(cfg.total_samples);
      push_data.env_flat = ~fade_in & ~fade_out;
      push_data.env_op   = fade_out ? (cfg.total_samples - n) : n;
      push_data.p32      = sstg_pkg::top32(sweep_base);

      sweep_in = done ? sweep_base
                      : sweep_base + sstg_pkg::scale_inc(cfg.lfo_increment);
      count_in = done ? n : n + sstg_pkg::COUNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         count_ff <= '0;
      end else if (push) begin
         sweep_ff <= sweep_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: src/sstg_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sstg_queue: short transaction queue between front and back
// Small FIFO of classified transactions.
// ---------------------------------------------------------------------------
module sstg_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sstg_pkg::job_type   push_data,
   input  logic                pop,
   output sstg_pkg::job_type   pop_data,
   output logic                full,
   output logic                empty
);

   sstg_pkg::job_type                 mem_ff [sstg_pkg::QUEUE_DEPTH];
   logic [sstg_pkg::QPTR_BITS-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [sstg_pkg::QPTR_BITS:0]      count_ff;

   assign full     = count_ff == (sstg_pkg::QPTR_BITS+1)'(sstg_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + sstg_pkg::QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + sstg_pkg::QPTR_BITS'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + (sstg_pkg::QPTR_BITS+1)'(1);
            2'b01:   count_ff <= count_ff - (sstg_pkg::QPTR_BITS+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: src/sstg_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sstg_back: sample synthesis sequencer
// Sweep multiply, audio phase update, quarter-wave sine lookup, envelope
// and gain scaling, then the output register.
// ---------------------------------------------------------------------------
module sstg_back (
   input  logic                clock,
   input  logic                reset,
   input  sstg_pkg::cfg_type   cfg,
   input  logic                q_empty,
   input  sstg_pkg::job_type   q_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_sample,
   output logic                rsp_last_sample
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_PHASE,
      ST_ROM,
      ST_SCALE,
      ST_OUT
   } state_type;

   localparam int STB = sstg_pkg::SINE_TABLE_BITS;
   localparam int PB  = sstg_pkg::PHASE_BITS;

   state_type                        state_ff;
   sstg_pkg::job_type                job_ff;
   logic [PB-1:0]                    audio_ff, audio_base, audio_in;
   logic [62:0]                      span_prod_ff;
   logic [40:0]                      env_prod_ff;
   logic [sstg_pkg::ENV_BITS-1:0]    env_ff, env_in;
   logic [15:0]                      tv_ff;
   logic                             neg_ff;
   logic [32:0]                      te_ff;
   logic                             rsp_valid_ff, rsp_valid_in, rsp_last_ff;
   logic signed [15:0]               rsp_sample_ff, sample_in;
   logic [31:0]                      u31_in, inc_in;
   logic [1:0]                       quad;
   logic [STB-1:0]                   raw_idx;
   logic [sstg_pkg::QIDX_BITS-1:0]   idx_in;
   logic [47:0]                      mag_prod;
   logic [16:0]                      mag;
   logic                             out_free;

   assign pop             = (state_ff == ST_IDLE) & ~q_empty;
   assign out_free        = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_last_sample = rsp_last_ff;

   always_comb begin
      u31_in     = job_ff.p32[31] ? (32'd0 - job_ff.p32) : job_ff.p32;
      inc_in     = 32'(cfg.start_increment) + span_prod_ff[62:31];
      audio_base = job_ff.restart ? '0 : audio_ff;
      audio_in   = job_ff.done ? audio_base
                               : audio_base + sstg_pkg::scale_inc(inc_in);
      env_in     = (job_ff.env_flat || env_prod_ff > 41'(sstg_pkg::ENV_ONE))
                   ? sstg_pkg::ENV_ONE : env_prod_ff[sstg_pkg::ENV_BITS-1:0];
      quad       = audio_ff[PB-1 -: 2];
      raw_idx    = audio_ff[PB-3 -: STB];
      idx_in     = quad[0] ? (sstg_pkg::QIDX_BITS'(1 << STB) - sstg_pkg::QIDX_BITS'(raw_idx))
                           : sstg_pkg::QIDX_BITS'(raw_idx);
      mag_prod   = 48'(te_ff) * 48'(cfg.gain);
      mag        = mag_prod[47:31];
      if (job_ff.done) begin
         sample_in = '0;
      end else if (neg_ff) begin
         sample_in = (mag > 17'd32768) ? 16'sh8000 : 16'(17'd0 - mag);
      end else begin
         sample_in = (mag > 17'd32767) ? 16'sh7fff : 16'(mag);
      end
      rsp_valid_in = ((state_ff == ST_OUT) && out_free) || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         audio_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  job_ff   <= q_data;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               span_prod_ff <= 63'(cfg.span_increment) * 63'(u31_in);
               state_ff     <= ST_PHASE;
            end
            ST_PHASE: begin
               audio_ff    <= audio_in;
               env_prod_ff <= 41'(job_ff.env_op) * 41'(cfg.fade_step);
               state_ff    <= ST_ROM;
            end
            ST_ROM: begin
               tv_ff    <= sstg_pkg::QTAB[idx_in];
               neg_ff   <= quad[1];
               env_ff   <= env_in;
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               te_ff    <= 33'(tv_ff) * 33'(env_ff);
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_sample_ff <= sample_in;
                  rsp_last_ff   <= job_ff.last & ~job_ff.done;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: src/swept_siren_tone_generator_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swept_siren_tone_generator_top: swept siren tone generator
// Each request transaction yields one signed 16-bit siren sample.
//
// Request channel (req_valid, req_stall, req_restart): one transaction per
// sample tick; restart clears both phases and the sample counter first.
// Response channel (rsp_valid, rsp_stall, rsp_sample, rsp_last_sample):
// one transaction per request, in order; last_sample marks the final
// sample of the tone, after which samples are silent.
// Configuration: APB-style port, registers at byte address 4*index.
// The back sequencer takes one queued request at a time and finishes its
// sample before it pops the next (multiply, phase add, table
// read, two scaling steps, output). A 2-entry queue lets the front take
// requests while the back works or the response waits.
// Reset clears phases, counter, queue and response valid, and loads the
// register defaults. While rsp_stall is high the response holds, the back
// waits, and req_stall rises once the queue fills.
// ---------------------------------------------------------------------------
module swept_siren_tone_generator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [15:0]                   rsp_sample,
   output logic                                 rsp_last_sample,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [sstg_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [sstg_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [sstg_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);

   sstg_pkg::cfg_type cfg;
   sstg_pkg::job_type push_data, pop_data;
   logic              push, pop, q_full, q_empty;

   assign pready = 1'b1;

   sstg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   sstg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .cfg         (cfg),
      .q_full      (q_full),
      .push        (push),
      .push_data   (push_data)
   );

   sstg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   sstg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .q_empty         (q_empty),
      .q_data          (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample      (rsp_sample),
      .rsp_last_sample (rsp_last_sample)
   );

endmodule

FILE: src/sstg_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sstg_checker: port-level checks of the siren generator
// Response hold, reset behavior and gain register write-back.
// ---------------------------------------------------------------------------
module sstg_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [15:0]                   rsp_sample,
   input logic                                 rsp_last_sample,
   input logic                                 psel,
   input logic                                 penable,
   input logic                                 pwrite,
   input logic [sstg_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input logic [sstg_pkg::CSR_DATA_BITS-1:0]   pwdata,
   input logic [sstg_pkg::CSR_DATA_BITS-1:0]   prdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample) &&
                                 $stable(rsp_last_sample))
      else $error("stalled response transaction changed");

   a_rst_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rst_req: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("request stalled after reset");

   a_gain_wb: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite &&
      paddr[sstg_pkg::CSR_ADDR_BITS-1:2] == sstg_pkg::CSR_GAIN
      |=> paddr[sstg_pkg::CSR_ADDR_BITS-1:2] != sstg_pkg::CSR_GAIN ||
          prdata == {17'd0, $past(pwdata[14:0])})
      else $error("gain register read-back mismatch");

endmodule

bind swept_siren_tone_generator_top sstg_checker u_checker (.*);
